// ===== rtl/core/tle_pkg.sv =====
// shared types and constants for the tranche loss expectation core
`default_nettype none

package tle_pkg;

  localparam int unsigned SUM_W     = 40;
  localparam int unsigned TALLY_W   = 9;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned MAG_LO_W  = 24;

  localparam logic [16:0]      ONE_Q16   = 17'd65536;
  localparam logic [SUM_W-1:0] SUM_MAX   = {SUM_W{1'b1}};
  localparam logic [8:0]       TALLY_MAX = 9'd511;

  localparam logic [15:0] ATTACH_RESET = 16'h0000;
  localparam logic [15:0] DETACH_RESET = 16'hFFFF;

  localparam logic signed [63:0] ACC_MAX = {1'b0, {63{1'b1}}};
  localparam logic signed [63:0] ACC_MIN = {1'b1, {63{1'b0}}};

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ATTACH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DETACH = 2'd1;

  // one classified name, handed from front to back
  typedef struct packed {
    logic [31:0] name_notional;
    logic [31:0] loss_term;
    logic        defaulted;
    logic        last_name;
    logic        new_run;
    logic [31:0] path_weight;
  } tle_entry_t;

  typedef enum logic [2:0] {
    FR_IDLE,
    FR_PROD,
    FR_REC,
    FR_MUL,
    FR_PUSH
  } tle_front_state_t;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_ATTACH,
    BK_CAP,
    BK_TRANCHE,
    BK_MAG,
    BK_MUL_LO,
    BK_MUL_HI,
    BK_WEIGHT,
    BK_ACCUM,
    BK_EMIT
  } tle_back_state_t;

endpackage

`default_nettype wire

// ===== rtl/core/tle_if.sv =====
// channel interfaces: name input, path result and configuration write
`default_nettype none

interface tle_in_if;
  logic               valid;
  logic               ready;
  logic [31:0]        name_notional;
  logic [16:0]        base_recovery;
  logic [15:0]        recovery_spread;
  logic signed [15:0] factor_draw;
  logic               survived;
  logic [31:0]        path_weight;
  logic               last_name;
  logic               new_run;

  modport source (
    output valid, name_notional, base_recovery, recovery_spread, factor_draw,
           survived, path_weight, last_name, new_run,
    input  ready
  );
  modport sink (
    input  valid, name_notional, base_recovery, recovery_spread, factor_draw,
           survived, path_weight, last_name, new_run,
    output ready
  );
endinterface

interface tle_out_if;
  logic               valid;
  logic               ready;
  logic signed [40:0] path_tranche_loss;
  logic [8:0]         path_default_count;
  logic signed [63:0] expected_loss;

  modport source (
    output valid, path_tranche_loss, path_default_count, expected_loss,
    input  ready
  );
  modport sink (
    input  valid, path_tranche_loss, path_default_count, expected_loss,
    output ready
  );
endinterface

interface tle_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [tle_pkg::CFG_IDX_W-1:0]  index;
  logic [15:0]                    data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/tle_front.sv =====
// front end: takes a name beat and works out its recovery-adjusted loss term
`default_nettype none

module tle_front (
  input  wire logic           clk,
  input  wire logic           rst_n,
  tle_in_if.sink              in_ch,
  output tle_pkg::tle_entry_t push_entry,
  output logic                push,
  input  wire logic           q_full
);

  tle_pkg::tle_front_state_t state_r, state_nxt;

  logic [31:0]        notional_r;
  logic [16:0]        base_r;
  logic [15:0]        spread_r;
  logic signed [15:0] draw_r;
  logic               survived_r;
  logic [31:0]        weight_r;
  logic               last_r;
  logic               new_run_r;
  logic signed [32:0] sd_r;
  logic [16:0]        one_minus_r;
  logic [31:0]        term_r;

  logic               load_in;
  logic signed [21:0] r_sum;
  logic [16:0]        rec;
  logic [48:0]        term_prod;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      tle_pkg::FR_IDLE: if (in_ch.valid) state_nxt = tle_pkg::FR_PROD;
      tle_pkg::FR_PROD: state_nxt = tle_pkg::FR_REC;
      tle_pkg::FR_REC:  state_nxt = tle_pkg::FR_MUL;
      tle_pkg::FR_MUL:  state_nxt = tle_pkg::FR_PUSH;
      tle_pkg::FR_PUSH: if (!q_full) state_nxt = tle_pkg::FR_IDLE;
      default:          state_nxt = tle_pkg::FR_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ch.ready = (state_r == tle_pkg::FR_IDLE);
    load_in     = (state_r == tle_pkg::FR_IDLE) && in_ch.valid;
    push        = (state_r == tle_pkg::FR_PUSH) && !q_full;
  end

  // recovery: base plus floored spread*draw, clamped to 0..1
  always_comb begin
    r_sum = $signed({5'b0, base_r}) + $signed(sd_r[32:12]);
    if (r_sum < 0) begin
      rec = 17'd0;
    end else if (r_sum > $signed({5'b0, tle_pkg::ONE_Q16})) begin
      rec = tle_pkg::ONE_Q16;
    end else begin
      rec = r_sum[16:0];
    end
    term_prod = {17'b0, notional_r} * {32'b0, one_minus_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tle_pkg::FR_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_in) begin
      notional_r <= in_ch.name_notional;
      base_r     <= in_ch.base_recovery;
      spread_r   <= in_ch.recovery_spread;
      draw_r     <= in_ch.factor_draw;
      survived_r <= in_ch.survived;
      weight_r   <= in_ch.path_weight;
      last_r     <= in_ch.last_name;
      new_run_r  <= in_ch.new_run;
    end
    if (state_r == tle_pkg::FR_PROD) sd_r <= $signed({1'b0, spread_r}) * draw_r;
    if (state_r == tle_pkg::FR_REC) one_minus_r <= tle_pkg::ONE_Q16 - rec;
    if (state_r == tle_pkg::FR_MUL) term_r <= term_prod[47:16];
  end

  always_comb begin
    push_entry.name_notional = notional_r;
    push_entry.loss_term     = term_r;
    push_entry.defaulted     = !survived_r;
    push_entry.last_name     = last_r;
    push_entry.new_run       = new_run_r;
    push_entry.path_weight   = weight_r;
  end

  a_term_le_notional: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tle_pkg::FR_PUSH) |-> (term_r <= notional_r))
    else $error("loss term exceeds notional");

endmodule

`default_nettype wire

// ===== rtl/core/tle_queue.sv =====
// short queue of classified names between front and back
`default_nettype none

module tle_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 push,
  input  wire tle_pkg::tle_entry_t  wr_entry,
  input  wire logic                 pop,
  output tle_pkg::tle_entry_t       rd_entry,
  output logic                      full,
  output logic                      empty
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

  tle_pkg::tle_entry_t slot_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;

  assign full     = (count_r == CNT_FULL);
  assign empty    = (count_r == '0);
  assign rd_entry = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= wr_entry;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
      if (push && !pop) count_r <= count_r + 1'b1;
      else if (pop && !push) count_r <= count_r - 1'b1;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_FULL)
    else $error("queue count beyond depth");

  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (count_r == $past(count_r) + 1'b1))
    else $error("push without pop did not grow the queue");

endmodule

`default_nettype wire

// ===== rtl/core/tle_back.sv =====
// back end: path accumulators, tranche loss and weighted expectation
`default_nettype none

module tle_back (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic [15:0]          attach,
  input  wire logic [15:0]          detach,
  input  wire logic                 q_empty,
  input  wire tle_pkg::tle_entry_t  q_head,
  output logic                      q_pop,
  tle_out_if.source                 out_ch
);

  tle_pkg::tle_back_state_t state_r, state_nxt;

  logic [39:0]        nsum_r, lsum_r;
  logic [8:0]         tally_r;
  logic signed [63:0] acc_r;
  logic [31:0]        weight_r;
  logic [39:0]        a1_r;
  logic signed [40:0] cap_r;
  logic signed [40:0] tranche_r;
  logic [39:0]        mag_r;
  logic               neg_r;
  logic [55:0]        plo_r;
  logic [47:0]        phi_r;
  logic signed [63:0] wval_r;
  logic               out_valid_r;
  logic signed [40:0] out_loss_r;
  logic [8:0]         out_count_r;
  logic signed [63:0] out_el_r;

  logic               out_free, out_load;
  logic [40:0]        nsum_add, lsum_add;
  logic [39:0]        nsum_sat, lsum_sat;
  logic [8:0]         tally_inc;
  logic [55:0]        a1_prod;
  logic signed [16:0] diff;
  logic signed [57:0] diff_x, nsum_x, cap_prod;
  logic signed [40:0] excess, excess_c, tranche, tr_neg;
  logic [71:0]        prod72;
  logic               ovf;
  logic signed [63:0] wval;
  logic signed [64:0] sum65;
  logic signed [63:0] acc_sat;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      tle_pkg::BK_IDLE: begin
        if (!q_empty && q_head.last_name) state_nxt = tle_pkg::BK_ATTACH;
      end
      tle_pkg::BK_ATTACH:  state_nxt = tle_pkg::BK_CAP;
      tle_pkg::BK_CAP:     state_nxt = tle_pkg::BK_TRANCHE;
      tle_pkg::BK_TRANCHE: state_nxt = tle_pkg::BK_MAG;
      tle_pkg::BK_MAG:     state_nxt = tle_pkg::BK_MUL_LO;
      tle_pkg::BK_MUL_LO:  state_nxt = tle_pkg::BK_MUL_HI;
      tle_pkg::BK_MUL_HI:  state_nxt = tle_pkg::BK_WEIGHT;
      tle_pkg::BK_WEIGHT:  state_nxt = tle_pkg::BK_ACCUM;
      tle_pkg::BK_ACCUM:   state_nxt = tle_pkg::BK_EMIT;
      tle_pkg::BK_EMIT:    if (out_free) state_nxt = tle_pkg::BK_IDLE;
      default:             state_nxt = tle_pkg::BK_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    out_free = !out_valid_r || out_ch.ready;
    q_pop    = (state_r == tle_pkg::BK_IDLE) && !q_empty;
    out_load = (state_r == tle_pkg::BK_EMIT) && out_free;
  end

  // datapath
  always_comb begin
    nsum_add  = {1'b0, nsum_r} + {9'b0, q_head.name_notional};
    nsum_sat  = nsum_add[40] ? tle_pkg::SUM_MAX : nsum_add[39:0];
    lsum_add  = {1'b0, lsum_r} + {9'b0, q_head.loss_term};
    lsum_sat  = lsum_add[40] ? tle_pkg::SUM_MAX : lsum_add[39:0];
    tally_inc = (tally_r == tle_pkg::TALLY_MAX) ? tally_r : tally_r + 9'd1;

    a1_prod  = {40'b0, attach} * {16'b0, nsum_r};
    diff     = $signed({1'b0, detach}) - $signed({1'b0, attach});
    diff_x   = {{41{diff[16]}}, diff};
    nsum_x   = {18'b0, nsum_r};
    cap_prod = diff_x * nsum_x;

    excess   = $signed({1'b0, lsum_r}) - $signed({1'b0, a1_r});
    excess_c = excess[40] ? '0 : excess;
    tranche  = (excess_c < cap_r) ? excess_c : cap_r;
    tr_neg   = -tranche_r;

    prod72 = {16'b0, plo_r} + {phi_r, 24'b0};
    ovf    = |prod72[71:63];
    if (ovf) begin
      wval = neg_r ? tle_pkg::ACC_MIN : tle_pkg::ACC_MAX;
    end else begin
      wval = neg_r ? -$signed(prod72[63:0]) : $signed(prod72[63:0]);
    end

    sum65 = {acc_r[63], acc_r} + {wval_r[63], wval_r};
    if (sum65[64] != sum65[63]) begin
      acc_sat = sum65[64] ? tle_pkg::ACC_MIN : tle_pkg::ACC_MAX;
    end else begin
      acc_sat = sum65[63:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tle_pkg::BK_IDLE;
      nsum_r      <= '0;
      lsum_r      <= '0;
      tally_r     <= '0;
      acc_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (q_pop) begin
        if (q_head.new_run) acc_r <= '0;
        nsum_r <= nsum_sat;
        if (q_head.defaulted) begin
          lsum_r  <= lsum_sat;
          tally_r <= tally_inc;
        end
      end
      if (state_r == tle_pkg::BK_ACCUM) acc_r <= acc_sat;
      if (out_load) begin
        nsum_r  <= '0;
        lsum_r  <= '0;
        tally_r <= '0;
      end
      if (out_load) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) weight_r <= q_head.path_weight;
    if (state_r == tle_pkg::BK_ATTACH) a1_r <= a1_prod[55:16];
    if (state_r == tle_pkg::BK_CAP) cap_r <= cap_prod[56:16];
    if (state_r == tle_pkg::BK_TRANCHE) tranche_r <= tranche;
    if (state_r == tle_pkg::BK_MAG) begin
      neg_r <= tranche_r[40];
      mag_r <= tranche_r[40] ? tr_neg[39:0] : tranche_r[39:0];
    end
    if (state_r == tle_pkg::BK_MUL_LO) plo_r <= {32'b0, mag_r[tle_pkg::MAG_LO_W-1:0]} * {24'b0, weight_r};
    if (state_r == tle_pkg::BK_MUL_HI) phi_r <= {32'b0, mag_r[39:tle_pkg::MAG_LO_W]} * {16'b0, weight_r};
    if (state_r == tle_pkg::BK_WEIGHT) wval_r <= wval;
    if (out_load) begin
      out_loss_r  <= tranche_r;
      out_count_r <= tally_r;
      out_el_r    <= acc_r;
    end
  end

  assign out_ch.valid              = out_valid_r;
  assign out_ch.path_tranche_loss  = out_loss_r;
  assign out_ch.path_default_count = out_count_r;
  assign out_ch.expected_loss      = out_el_r;

  a_loss_le_total: assert property (@(posedge clk) disable iff (!rst_n)
    lsum_r <= nsum_r)
    else $error("path loss exceeds path notional");

  a_path_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> (nsum_r == '0) && (lsum_r == '0) && (tally_r == '0))
    else $error("path accumulators not cleared after result");

  a_tranche_capped: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tle_pkg::BK_MAG) |-> (tranche_r <= cap_r))
    else $error("tranche loss above cap");

endmodule

`default_nettype wire

// ===== rtl/core/tranche_loss_expectation_core.sv =====
// top level: strike registers, front end, name queue and back end
// path end: a path's last name passes the front states prod, rec, mul and push, the queue,
//   then the back states attach through emit before out valid, with queue empty and out free
// flow: the front recovery/loss sequencer takes a new name beat only once the last one is
//   pushed; the back takes no further names while it works out a path end, so the front
//   stalls once the queue fills, and out ready stalls add on top
// reset (rst_n low, synchronous): clears sequencers, queue, path and expectation
//   accumulators, attach strike to 0 and detach strike to 0xffff; no clearing pass
`default_nettype none

module tranche_loss_expectation_core #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  tle_in_if.sink     in_ch,
  tle_out_if.source  out_ch,
  tle_cfg_if.sink    cfg_ch
);

  // strike registers; the user must write them only while the core is idle (not enforced here)
  logic [15:0] attach_r;
  logic [15:0] detach_r;

  // front to queue
  tle_pkg::tle_entry_t push_entry;
  logic                push;
  logic                q_full;

  // queue to back
  tle_pkg::tle_entry_t q_head;
  logic                q_pop;
  logic                q_empty;

  // configuration writes are always taken
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attach_r <= tle_pkg::ATTACH_RESET;
      detach_r <= tle_pkg::DETACH_RESET;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        tle_pkg::CFG_ATTACH: attach_r <= cfg_ch.data;
        tle_pkg::CFG_DETACH: detach_r <= cfg_ch.data;
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  // front: one name at a time, recovery clamp and loss term
  tle_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .push_entry (push_entry),
    .push       (push),
    .q_full     (q_full)
  );

  // decouples the name sequencer from the path-end arithmetic
  tle_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .wr_entry (push_entry),
    .pop      (q_pop),
    .rd_entry (q_head),
    .full     (q_full),
    .empty    (q_empty)
  );

  // back: accumulate, then tranche and weighted expectation on a path end
  tle_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .attach  (attach_r),
    .detach  (detach_r),
    .q_empty (q_empty),
    .q_head  (q_head),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule

`default_nettype wire
